/* src/mvst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvst_pkg
// Shared types and constants for the marked value set table.
// ----------------------------------------------------------------------------
package mvst_pkg;

   localparam int VALUE_W  = 32;
   localparam int OPCODE_W = 3;
   localparam int POS_W    = 7;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT     = 3'd0,
      OP_TOUCH      = 3'd1,
      OP_FIND       = 3'd2,
      OP_DELETE     = 3'd3,
      OP_SWEEP      = 3'd4,
      OP_CLEAR_MARK = 3'd5,
      OP_CLEAR_ALL  = 3'd6
   } op_type;

   typedef enum logic [3:0] {
      CELL_HOLD,
      CELL_MATCH,
      CELL_INSERT,
      CELL_MARK,
      CELL_DELETE,
      CELL_SWEEP,
      CELL_CLEAR_MARK,
      CELL_CLEAR_ALL,
      CELL_COMPACT
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_EXEC,
      ST_COMPACT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic               live;
      logic               mark;
      logic [VALUE_W-1:0] value;
   } cell_data_type;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] position;
      logic             pending;
      logic             full;
   } status_type;

endpackage

/* src/mvst_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvst_cell
// One entry of the table: value, mark, live flag and a registered match bit.
// Exchanges its contents with its neighbors on insert and compaction.
// ----------------------------------------------------------------------------
module mvst_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  mvst_pkg::cell_cmd_type       cmd,
   input  logic [mvst_pkg::VALUE_W-1:0] key,
   input  mvst_pkg::cell_data_type      left_data,
   input  mvst_pkg::cell_data_type      right_data,
   output mvst_pkg::cell_data_type      cell_data,
   output logic                         match
);
   import mvst_pkg::*;

   logic               live_ff, live_in;
   logic               mark_ff, mark_in;
   logic               match_ff, match_in;
   logic [VALUE_W-1:0] value_ff, value_in;

   always_comb begin
      live_in  = live_ff;
      mark_in  = mark_ff;
      value_in = value_ff;
      match_in = match_ff;
      case (cmd)
         CELL_MATCH: begin
            match_in = live_ff && (value_ff == key);
         end
         CELL_INSERT: begin
            live_in  = left_data.live;
            mark_in  = left_data.mark;
            value_in = left_data.value;
         end
         CELL_MARK: begin
            if (match_ff) begin
               mark_in = 1'b1;
            end
         end
         CELL_DELETE: begin
            if (match_ff) begin
               live_in = 1'b0;
               mark_in = 1'b0;
            end
         end
         CELL_SWEEP: begin
            if (!mark_ff) begin
               live_in = 1'b0;
            end
         end
         CELL_CLEAR_MARK: begin
            mark_in = 1'b0;
         end
         CELL_CLEAR_ALL: begin
            live_in = 1'b0;
            mark_in = 1'b0;
         end
         CELL_COMPACT: begin
            // A hole swaps with the live entry on its right, so every gap
            // drifts one cell toward the tail per cycle.
            if (!live_ff && right_data.live) begin
               live_in  = 1'b1;
               mark_in  = right_data.mark;
               value_in = right_data.value;
            end else if (live_ff && !left_data.live) begin
               live_in = 1'b0;
               mark_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= 1'b0;
         mark_ff  <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         live_ff  <= live_in;
         mark_ff  <= mark_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_data.live  = live_ff;
   assign cell_data.mark  = mark_ff;
   assign cell_data.value = value_ff;
   assign match           = match_ff;

endmodule

/* src/mvst_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvst_ctrl
// Sequencer of the table: takes one transaction, drives the cell commands
// through compare, execute and compaction, and holds the result.
// ----------------------------------------------------------------------------
module mvst_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mvst_pkg::OPCODE_W-1:0] req_opcode,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mvst_pkg::POS_W-1:0]    rsp_position,
   output logic                          rsp_hit,
   output logic                          rsp_full,
   input  mvst_pkg::status_type          status,
   output mvst_pkg::cell_cmd_type        cmd
);
   import mvst_pkg::*;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             hit_ff, hit_in;
   logic             full_ff, full_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if ((op_ff == OP_DELETE && status.hit) || op_ff == OP_SWEEP) begin
               state_in = ST_COMPACT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_COMPACT: begin
            if (!status.pending) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_RESP);
      op_in      = op_ff;
      pos_in     = pos_ff;
      hit_in     = hit_ff;
      full_in    = full_ff;
      cmd        = CELL_HOLD;
      case (state_ff)
         ST_IDLE: begin
            op_in = op_type'(req_opcode);
         end
         ST_MATCH: begin
            cmd = CELL_MATCH;
         end
         ST_EXEC: begin
            pos_in  = '0;
            hit_in  = 1'b0;
            full_in = 1'b0;
            case (op_ff)
               OP_INSERT: begin
                  if (status.hit) begin
                     cmd    = CELL_MARK;
                     pos_in = status.position;
                     hit_in = 1'b1;
                  end else if (status.full) begin
                     full_in = 1'b1;
                  end else begin
                     cmd = CELL_INSERT;
                  end
               end
               OP_TOUCH: begin
                  cmd    = CELL_MARK;
                  pos_in = status.hit ? status.position : '0;
                  hit_in = status.hit;
               end
               OP_FIND: begin
                  pos_in = status.hit ? status.position : '0;
                  hit_in = status.hit;
               end
               OP_DELETE: begin
                  cmd    = CELL_DELETE;
                  pos_in = status.hit ? status.position : '0;
                  hit_in = status.hit;
               end
               OP_SWEEP: begin
                  cmd = CELL_SWEEP;
               end
               OP_CLEAR_MARK: begin
                  cmd = CELL_CLEAR_MARK;
               end
               OP_CLEAR_ALL: begin
                  cmd = CELL_CLEAR_ALL;
               end
               default: begin
               end
            endcase
         end
         ST_COMPACT: begin
            cmd = status.pending ? CELL_COMPACT : CELL_HOLD;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      pos_ff  <= pos_in;
      hit_ff  <= hit_in;
      full_ff <= full_in;
   end

   assign rsp_position = pos_ff;
   assign rsp_hit      = hit_ff;
   assign rsp_full     = full_ff;

endmodule

/* src/marked_value_set_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marked_value_set_table
// Set of distinct 32-bit values kept newest first, one mark bit per entry,
// built as a row of cells with a broadcast compare.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Insert, touch, find, clear marks,
// clear all and a delete that misses pass through accept, compare in every
// cell, execute and respond. The result is registered in the execute step
// and offered in the respond step. A delete that removes an entry and every
// sweep then close their gaps in the cell row, where each gap moves one cell
// per cycle, until the row is seen settled. The result stays offered until
// it is taken, and the next request is accepted after that.
// ----------------------------------------------------------------------------
module marked_value_set_table #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [6:0] position, [7] hit, [8] full_res, rest zero
);
   import mvst_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   cell_data_type       cell_q [CAPACITY];
   logic [CAPACITY-1:0] match_vec;
   cell_cmd_type        cmd;
   status_type          status;
   logic [VALUE_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0]    match_idx;
   logic                pending;
   logic [POS_W-1:0]    rsp_position;
   logic                rsp_hit;
   logic                rsp_full;

   // The compare key is captured with the request.
   assign key_in = (req_tvalid && req_tready) ? req_tdata : key_ff;

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         cell_data_type left_d;
         cell_data_type right_d;

         if (gi == 0) begin : g_head
            assign left_d.live  = 1'b1;
            assign left_d.mark  = 1'b1;
            assign left_d.value = key_ff;
         end else begin : g_body
            assign left_d = cell_q[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_tail
            assign right_d = '0;
         end else begin : g_next
            assign right_d = cell_q[gi+1];
         end

         mvst_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .key        (key_ff),
            .left_data  (left_d),
            .right_data (right_d),
            .cell_data  (cell_q[gi]),
            .match      (match_vec[gi])
         );
      end
   endgenerate

   // Values are distinct, so at most one match bit is set and an OR of the
   // indexes gives its position.
   always_comb begin
      match_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_vec[i]) begin
            match_idx = match_idx | IDX_W'(i);
         end
      end
   end

   // A gap remains wherever an empty cell has a live one on its right.
   always_comb begin
      pending = 1'b0;
      for (int i = 0; i < CAPACITY - 1; i++) begin
         if (!cell_q[i].live && cell_q[i+1].live) begin
            pending = 1'b1;
         end
      end
   end

   assign status.hit      = |match_vec;
   assign status.position = POS_W'({1'b0, match_idx} + 1'b1);
   assign status.pending  = pending;
   assign status.full     = cell_q[CAPACITY-1].live;

   mvst_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_opcode   (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_position (rsp_position),
      .rsp_hit      (rsp_hit),
      .rsp_full     (rsp_full),
      .status       (status),
      .cmd          (cmd)
   );

   assign rsp_tdata = {7'b0, rsp_full, rsp_hit, rsp_position};

   // Only one transaction is in flight.
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a result is outstanding");

   // Compaction must be complete before a result is offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !pending)
      else $error("result offered with a gap left in the table");

   // Distinct values can never match in two cells.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one cell matched the key");

   // A full report never comes with a hit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_full && rsp_hit))
      else $error("full and hit reported together");

endmodule
